// ----- src/rgb_to_nv21_pixel_converter_defines.svh -----
// Assertion macros for the RGB to NV21 converter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef RGB_TO_NV21_PIXEL_CONVERTER_DEFINES_SVH
`define RGB_TO_NV21_PIXEL_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RGBNV21_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RGBNV21_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rgbnv21_pkg.sv -----
// Shared types, constants and helpers for the RGB to NV21 converter.
// No dependencies.
package rgbnv21_pkg;

	localparam int PIX_W = 8;
	localparam int CNT_W = 12;
	localparam int DIM_W = 13;
	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	localparam logic [DIM_W-1:0] LINE_WIDTH_RESET   = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

	// register indexes
	localparam logic CFG_LINE_WIDTH   = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic even_col;
		logic odd_row;
		logic frame_end;
	} pos_t;

	// last index for a configured size; zero acts as one, oversize as the max
	function automatic logic [CNT_W-1:0] dim_last(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] d;
		begin
			if (dim == '0) begin
				d = 13'd1;
			end else if (dim > MAX_DIM) begin
				d = MAX_DIM;
			end else begin
				d = dim;
			end
			dim_last = CNT_W'(d - 13'd1);
		end
	endfunction

	function automatic logic [PIX_W-1:0] sat_byte(input logic signed [10:0] q);
		begin
			if (q < 0) begin
				sat_byte = '0;
			end else if (q > 11'sd255) begin
				sat_byte = 8'hFF;
			end else begin
				sat_byte = q[7:0];
			end
		end
	endfunction

endpackage

// ----- src/rgbnv21_csc.sv -----
// BT.601 color space conversion for one pixel: luma and the Cb or Cr byte.
// Combinational; depends on rgbnv21_pkg.
module rgbnv21_csc (
	input  logic [rgbnv21_pkg::PIX_W-1:0] blue,
	input  logic [rgbnv21_pkg::PIX_W-1:0] green,
	input  logic [rgbnv21_pkg::PIX_W-1:0] red,
	input  rgbnv21_pkg::pos_t             pos,
	output logic [rgbnv21_pkg::PIX_W-1:0] luma,
	output logic [rgbnv21_pkg::PIX_W-1:0] chroma
);
	import rgbnv21_pkg::*;

	logic        [15:0] y_sum;
	logic signed [16:0] bs, gs, rs;
	logic signed [16:0] cb_sum, cr_sum;
	logic signed [10:0] y_q, cb_q, cr_q;

	assign y_sum = 16'd66 * {8'd0, red} + 16'd129 * {8'd0, green}
		+ 16'd25 * {8'd0, blue} + 16'd128;

	assign bs = signed'({9'd0, blue});
	assign gs = signed'({9'd0, green});
	assign rs = signed'({9'd0, red});

	assign cb_sum = -17'sd38 * rs - 17'sd74 * gs + 17'sd112 * bs + 17'sd128;
	assign cr_sum = 17'sd112 * rs - 17'sd94 * gs - 17'sd18 * bs + 17'sd128;

	// arithmetic shift gives floor division for negative sums
	assign y_q  = signed'({3'd0, y_sum[15:8]}) + 11'sd16;
	assign cb_q = 11'(cb_sum >>> 8) + 11'sd128;
	assign cr_q = 11'(cr_sum >>> 8) + 11'sd128;

	always_comb begin
		luma = sat_byte(y_q);
		if (!pos.even_col) begin
			chroma = '0;
		end else if (pos.odd_row) begin
			chroma = sat_byte(cr_q);
		end else begin
			chroma = sat_byte(cb_q);
		end
	end

endmodule

// ----- src/rgb_to_nv21_pixel_converter.sv -----
// Top level of the RGB to NV21 pixel converter.
// Depends on rgbnv21_pkg, rgbnv21_csc and rgb_to_nv21_pixel_converter_defines.svh.
//
// Usage:
//  - Pixels enter on the s_ stream, one per request: blue, green, red bytes.
//  - Each pixel gives one request on the m_ stream: luma, plus a chroma byte
//    on even columns (Cb on even rows, Cr on odd rows) flagged in m_tuser.
//    m_tlast marks the last pixel of the frame.
//  - line_width and frame_height are written on the cfg port while idle;
//    zero acts as 1 and sizes above 4096 act as 4096. Writes keep the
//    position counters.
//  - There are two registers: an input register holds the pixel and its
//    position flags, the conversion logic feeds the output register.
//  - Throughput is one pixel per cycle while m_tready is high; s_tready stays
//    high while either register is empty or the output register is being drained.
//  - When m_tready is low the result holds, the input register fills, and
//    s_tready then drops until the receiver takes the result.
//  - Reset clears the counters to the frame origin, empties both registers
//    and restores 640 x 480.
module rgb_to_nv21_pixel_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // luma[7:0], chroma[15:8]
	output logic [1:0]  m_tuser,   // chroma_valid[0], chroma_is_red_diff[1]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [rgbnv21_pkg::DIM_W-1:0] cfg_data
);
	import rgbnv21_pkg::*;

	logic [DIM_W-1:0] line_width_q, frame_height_q;
	logic [CNT_W-1:0] column_q, row_q;
	logic [CNT_W-1:0] last_col, last_row;
	logic             end_col, end_row, accept, s2_load;

	logic             valid_s1, valid_s2;
	logic [PIX_W-1:0] blue_s1, green_s1, red_s1;
	pos_t             pos_s1, pos_s2, pos_next;
	logic [PIX_W-1:0] luma_s2, chroma_s2, luma_c, chroma_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign last_col = dim_last(line_width_q);
	assign last_row = dim_last(frame_height_q);
	assign end_col  = column_q >= last_col;
	assign end_row  = row_q >= last_row;

	assign s2_load  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_next.even_col  = ~column_q[0];
	assign pos_next.odd_row   = row_q[0];
	assign pos_next.frame_end = end_col && end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (end_col) begin
				column_q <= '0;
				row_q    <= end_row ? '0 : row_q + 12'd1;
			end else begin
				column_q <= column_q + 12'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1  <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			red_s1   <= s_tdata[23:16];
			pos_s1   <= pos_next;
		end
		if (s2_load) begin
			luma_s2   <= luma_c;
			chroma_s2 <= chroma_c;
			pos_s2    <= pos_s1;
		end
	end

	rgbnv21_csc u_csc (
		.blue   (blue_s1),
		.green  (green_s1),
		.red    (red_s1),
		.pos    (pos_s1),
		.luma   (luma_c),
		.chroma (chroma_c)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {chroma_s2, luma_s2};
	assign m_tuser  = {pos_s2.even_col & pos_s2.odd_row, pos_s2.even_col};
	assign m_tlast  = pos_s2.frame_end;

`include "rgb_to_nv21_pixel_converter_defines.svh"

	`RGBNV21_ASSERT_NEXT(a_s1_to_s2, s2_load, valid_s2, "result lost moving to output register")
	`RGBNV21_ASSERT_IMPL(a_cr_flag, valid_s2 && m_tuser[1], m_tuser[0], "Cr flag without chroma")
	`RGBNV21_ASSERT_NEXT(a_col0_even, accept && column_q == '0, pos_s1.even_col, "column 0 not even")
	`RGBNV21_ASSERT_NEXT(a_wrap, accept && end_col, column_q == '0, "column did not wrap")

endmodule
